// ----- src/lpr_pkg.sv -----
// lpr_pkg: shared widths, register indexes and reset values of the line pixel rasteriser.
// No dependencies; imported by the top level and the checker.
`default_nettype none
package lpr_pkg;

   localparam int IDX_BITS     = 11;
   localparam int COLOR_BITS   = 16;
   localparam int OUT_BITS     = 13;
   localparam int ADDR_BITS    = 32;
   localparam int LIMIT_BITS   = 11;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [ADDR_BITS-1:0]  FRAME_BASE_RESET = 32'hC800_0000;
   localparam logic [LIMIT_BITS-1:0] WIDTH_RESET      = 11'd640;
   localparam logic [LIMIT_BITS-1:0] HEIGHT_RESET     = 11'd480;

   // register map of the csr port
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FRAME_BASE   = 2'd0,
      CSR_WIDTH_LIMIT  = 2'd1,
      CSR_HEIGHT_LIMIT = 2'd2
   } csr_index_type;

   // how the pixel is derived
   typedef enum logic [1:0] {
      MODE_BOX     = 2'd0,
      MODE_SHALLOW = 2'd1,
      MODE_STEEP   = 2'd2
   } mode_type;

   // start-to-response latency in cycles
   function automatic int lpr_latency(input int coord_bits);
      return 5 * coord_bits + 8;
   endfunction

endpackage
`default_nettype wire

// ----- src/lpr_div_cell.sv -----
// lpr_div_cell: one restoring-division cell, producing one quotient bit per request.
// Stand-alone; chained by lpr_divider.
`default_nettype none
module lpr_div_cell #(
   parameter int DW = 22,
   parameter int VW = 12,
   parameter int PW = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire logic [VW-1:0] in_rem,
   input  wire logic [DW-1:0] in_work,
   input  wire logic [VW-1:0] in_dvs,
   input  wire logic [PW-1:0] in_side,
   output logic               out_valid,
   output logic [VW-1:0]      out_rem,
   output logic [DW-1:0]      out_work,
   output logic [VW-1:0]      out_dvs,
   output logic [PW-1:0]      out_side
);

   logic          valid_ff;
   logic [VW-1:0] rem_ff, rem_in;
   logic [DW-1:0] work_ff, work_in;
   logic [VW-1:0] dvs_ff;
   logic [PW-1:0] side_ff;
   logic [VW:0]   trial, diff;
   logic          ge;

   // shift in the next dividend bit and try the subtract
   always_comb begin
      trial   = {in_rem, in_work[DW-1]};
      diff    = trial - {1'b0, in_dvs};
      ge      = (trial >= {1'b0, in_dvs});
      rem_in  = ge ? diff[VW-1:0] : trial[VW-1:0];
      work_in = {in_work[DW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      rem_ff  <= rem_in;
      work_ff <= work_in;
      dvs_ff  <= in_dvs;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_work  = work_ff;
   assign out_dvs   = dvs_ff;
   assign out_side  = side_ff;

endmodule
`default_nettype wire

// ----- src/lpr_divider.sv -----
// lpr_divider: unsigned divider built as a row of lpr_div_cell, one cell per quotient bit.
// Depends on lpr_div_cell. Each cell is a register stage; one request per cycle.
`default_nettype none
module lpr_divider #(
   parameter int DW = 22,
   parameter int VW = 12,
   parameter int PW = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire logic [DW-1:0] in_dividend,
   input  wire logic [VW-1:0] in_divisor,
   input  wire logic [PW-1:0] in_side,
   output logic               out_valid,
   output logic [DW-1:0]      out_quotient,
   output logic [VW-1:0]      out_remainder,
   output logic [PW-1:0]      out_side
);

   logic          v_q    [0:DW];
   logic [VW-1:0] rem_q  [0:DW];
   logic [DW-1:0] work_q [0:DW];
   logic [VW-1:0] dvs_q  [0:DW];
   logic [PW-1:0] side_q [0:DW];

   assign v_q[0]    = in_valid;
   assign rem_q[0]  = '0;
   assign work_q[0] = in_dividend;
   assign dvs_q[0]  = in_divisor;
   assign side_q[0] = in_side;

   // one cell per quotient bit, MSB first
   for (genvar i = 0; i < DW; i++) begin : g_cell
      lpr_div_cell #(.DW(DW), .VW(VW), .PW(PW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v_q[i]),
         .in_rem    (rem_q[i]),
         .in_work   (work_q[i]),
         .in_dvs    (dvs_q[i]),
         .in_side   (side_q[i]),
         .out_valid (v_q[i+1]),
         .out_rem   (rem_q[i+1]),
         .out_work  (work_q[i+1]),
         .out_dvs   (dvs_q[i+1]),
         .out_side  (side_q[i+1])
      );
   end

   assign out_valid     = v_q[DW];
   assign out_quotient  = work_q[DW];
   assign out_remainder = rem_q[DW];
   assign out_side      = side_q[DW];

endmodule
`default_nettype wire

// ----- src/line_pixel_rasterizer.sv -----
// Line pixel rasteriser: one pixel of a box or sloped line per request, fully pipelined.
// Path: capture, deltas, first divider, intercept, products, second divider, output.
// Throughput one request per cycle, set by the two divider cell rows (2*C and 3*C+3 cells).
// busy is high only during reset; the receiver cannot stall, results strobe for one cycle.
// Synchronous reset flushes the pipeline and loads the register reset values.
// Depends on lpr_pkg and lpr_divider.
`default_nettype none
module line_pixel_rasterizer #(
   parameter int ROW_SHIFT  = 10,
   parameter int COORD_BITS = 11
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [COORD_BITS-1:0]               req_start_x,
   input  wire logic [COORD_BITS-1:0]               req_start_y,
   input  wire logic [COORD_BITS-1:0]               req_end_x,
   input  wire logic [COORD_BITS-1:0]               req_end_y,
   input  wire logic [lpr_pkg::COLOR_BITS-1:0]      req_color_in,
   input  wire logic [lpr_pkg::IDX_BITS-1:0]        req_pixel_index,
   output logic                                     rsp_valid,
   output logic signed [lpr_pkg::OUT_BITS-1:0]      rsp_pixel_x,
   output logic signed [lpr_pkg::OUT_BITS-1:0]      rsp_pixel_y,
   output logic [lpr_pkg::ADDR_BITS-1:0]            rsp_pixel_address,
   output logic [lpr_pkg::COLOR_BITS-1:0]           rsp_color_out,
   output logic                                     rsp_is_valid,
   output logic                                     rsp_is_last,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lpr_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [lpr_pkg::ADDR_BITS-1:0]       csr_wdata
);
   import lpr_pkg::*;

   localparam int C   = COORD_BITS;
   localparam int SW  = C + 1;                       // signed delta
   localparam int VW  = C + 1;                       // divisor
   localparam int LW  = (C > LIMIT_BITS) ? C : LIMIT_BITS;
   localparam int CNW = 2 * C + 2;                   // pixel count
   localparam int DW1 = 2 * C;                       // intercept dividend
   localparam int BW  = 2 * C + 1;                   // intercept
   localparam int TW  = 2 * C + 2;
   localparam int NW  = 3 * C + 4;                   // second numerator
   localparam int DW2 = NW - 1;
   localparam int FW  = DW2 + 1;

   typedef struct packed {
      mode_type              mode;
      logic                  in_range;
      logic                  last;
      logic                  qneg;
      logic [COLOR_BITS-1:0] color;
      logic [IDX_BITS-1:0]   idx;
      logic [C-1:0]          x1;
      logic [C-1:0]          y1;
      logic [SW-1:0]         dx;
      logic [SW-1:0]         dy;
      logic [LW-1:0]         lo;
   } side1_type;

   typedef struct packed {
      mode_type              mode;
      logic                  in_range;
      logic                  last;
      logic                  qneg;
      logic [COLOR_BITS-1:0] color;
      logic [C-1:0]          cx;
      logic [C-1:0]          cy;
   } side2_type;

   localparam int PW1 = $bits(side1_type);
   localparam int PW2 = $bits(side2_type);

   // ---------------- configuration registers ----------------
   logic [ADDR_BITS-1:0]  frame_base_ff;
   logic [LIMIT_BITS-1:0] width_limit_ff, height_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff   <= FRAME_BASE_RESET;
         width_limit_ff  <= WIDTH_RESET;
         height_limit_ff <= HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_BASE:   frame_base_ff   <= csr_wdata;
            CSR_WIDTH_LIMIT:  width_limit_ff  <= csr_wdata[LIMIT_BITS-1:0];
            CSR_HEIGHT_LIMIT: height_limit_ff <= csr_wdata[LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = reset;

   // ---------------- stage 0: capture request ----------------
   logic                  p0_valid_ff;
   logic [C-1:0]          p0_x1_ff, p0_y1_ff, p0_x2_ff, p0_y2_ff;
   logic [COLOR_BITS-1:0] p0_color_ff;
   logic [IDX_BITS-1:0]   p0_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
      end else begin
         p0_valid_ff <= start;
      end
      p0_x1_ff    <= req_start_x;
      p0_y1_ff    <= req_start_y;
      p0_x2_ff    <= req_end_x;
      p0_y2_ff    <= req_end_y;
      p0_color_ff <= req_color_in;
      p0_idx_ff   <= req_pixel_index;
   end

   // ---------------- stage 1: deltas, clamps, products ----------------
   logic signed [SW-1:0] dx_in, dy_in;
   logic [SW-1:0]        adx_in, ady_in, w_in, h_in;
   mode_type             mode_in;
   logic                 box_ok_in;
   logic [LW-1:0]        lim_in, mn_in, mx_in, lo_in, hi_in;

   logic                  p1_valid_ff, p1_box_ok_ff;
   mode_type              p1_mode_ff;
   logic [COLOR_BITS-1:0] p1_color_ff;
   logic [IDX_BITS-1:0]   p1_idx_ff;
   logic [C-1:0]          p1_x1_ff, p1_y1_ff;
   logic [SW-1:0]         p1_dx_ff, p1_dy_ff, p1_adx_ff, p1_w_ff;
   logic [LW-1:0]         p1_lo_ff, p1_hi_ff;
   logic [2*C-1:0]        p1_prod_a_ff, p1_prod_b_ff;
   logic [CNW-1:0]        p1_box_cnt_ff;

   always_comb begin
      dx_in     = signed'(SW'(p0_x2_ff)) - signed'(SW'(p0_x1_ff));
      dy_in     = signed'(SW'(p0_y2_ff)) - signed'(SW'(p0_y1_ff));
      adx_in    = dx_in[SW-1] ? SW'(-dx_in) : SW'(dx_in);
      ady_in    = dy_in[SW-1] ? SW'(-dy_in) : SW'(dy_in);
      w_in      = SW'(p0_x2_ff) - SW'(p0_x1_ff) + SW'(1);
      h_in      = SW'(p0_y2_ff) - SW'(p0_y1_ff) + SW'(1);
      box_ok_in = (p0_x1_ff <= p0_x2_ff) && (p0_y1_ff <= p0_y2_ff);
      if ((p0_x1_ff == p0_x2_ff) || (p0_y1_ff == p0_y2_ff)) begin
         mode_in = MODE_BOX;
      end else if (ady_in < adx_in) begin
         mode_in = MODE_SHALLOW;
      end else begin
         mode_in = MODE_STEEP;
      end
      // clamp the stepped axis to its limit
      if (mode_in == MODE_SHALLOW) begin
         lim_in = LW'(width_limit_ff);
         mn_in  = LW'((p0_x1_ff < p0_x2_ff) ? p0_x1_ff : p0_x2_ff);
         mx_in  = LW'((p0_x1_ff < p0_x2_ff) ? p0_x2_ff : p0_x1_ff);
      end else begin
         lim_in = LW'(height_limit_ff);
         mn_in  = LW'((p0_y1_ff < p0_y2_ff) ? p0_y1_ff : p0_y2_ff);
         mx_in  = LW'((p0_y1_ff < p0_y2_ff) ? p0_y2_ff : p0_y1_ff);
      end
      lo_in = (mn_in < lim_in) ? mn_in : lim_in;
      hi_in = (mx_in < lim_in) ? mx_in : lim_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= p0_valid_ff;
      end
      p1_mode_ff    <= mode_in;
      p1_box_ok_ff  <= box_ok_in;
      p1_color_ff   <= p0_color_ff;
      p1_idx_ff     <= p0_idx_ff;
      p1_x1_ff      <= p0_x1_ff;
      p1_y1_ff      <= p0_y1_ff;
      p1_dx_ff      <= dx_in;
      p1_dy_ff      <= dy_in;
      p1_adx_ff     <= adx_in;
      p1_w_ff       <= w_in;
      p1_lo_ff      <= lo_in;
      p1_hi_ff      <= hi_in;
      p1_prod_a_ff  <= p0_y1_ff * p0_x2_ff;
      p1_prod_b_ff  <= p0_y2_ff * p0_x1_ff;
      p1_box_cnt_ff <= CNW'(w_in * h_in);
   end

   // ---------------- stage 2: intercept numerator, count, first divider ----------------
   logic signed [BW-1:0] num1;
   logic [DW1-1:0]       div1_dividend;
   logic [VW-1:0]        div1_divisor;
   logic [CNW-1:0]       count;
   side1_type            s1_in, s1_out;
   logic                 d1_valid;
   logic [DW1-1:0]       d1_quot;
   logic [VW-1:0]        d1_rem;
   logic [PW1-1:0]       d1_side;

   always_comb begin
      num1 = signed'({1'b0, p1_prod_a_ff}) - signed'({1'b0, p1_prod_b_ff});
      if (p1_mode_ff == MODE_BOX) begin
         count         = p1_box_ok_ff ? p1_box_cnt_ff : '0;
         div1_dividend = DW1'(p1_idx_ff);
         div1_divisor  = p1_w_ff;
      end else begin
         count         = CNW'(p1_hi_ff - p1_lo_ff);
         div1_dividend = num1[BW-1] ? DW1'(-num1) : DW1'(num1);
         div1_divisor  = p1_adx_ff;
      end
      s1_in.mode     = p1_mode_ff;
      s1_in.in_range = CNW'(p1_idx_ff) < count;
      s1_in.last     = (CNW'(p1_idx_ff) + CNW'(1)) == count;
      s1_in.qneg     = num1[BW-1] ^ p1_dx_ff[SW-1];
      s1_in.color    = p1_color_ff;
      s1_in.idx      = p1_idx_ff;
      s1_in.x1       = p1_x1_ff;
      s1_in.y1       = p1_y1_ff;
      s1_in.dx       = p1_dx_ff;
      s1_in.dy       = p1_dy_ff;
      s1_in.lo       = p1_lo_ff;
   end

   lpr_divider #(.DW(DW1), .VW(VW), .PW(PW1)) u_div_icpt (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (p1_valid_ff),
      .in_dividend   (div1_dividend),
      .in_divisor    (div1_divisor),
      .in_side       (PW1'(s1_in)),
      .out_valid     (d1_valid),
      .out_quotient  (d1_quot),
      .out_remainder (d1_rem),
      .out_side      (d1_side)
   );

   assign s1_out = side1_type'(d1_side);

   // ---------------- stage 3: intercept and stepped coordinate ----------------
   logic signed [BW-1:0] b_in;
   logic [LW:0]          step_sum;
   logic [C-1:0]         cx_in, cy_in;

   logic                  p3_valid_ff, p3_in_range_ff, p3_last_ff;
   mode_type              p3_mode_ff;
   logic [COLOR_BITS-1:0] p3_color_ff;
   logic [SW-1:0]         p3_dx_ff, p3_dy_ff;
   logic [BW-1:0]         p3_b_ff;
   logic [C-1:0]          p3_cx_ff, p3_cy_ff;

   always_comb begin
      b_in     = s1_out.qneg ? -signed'(BW'(d1_quot)) : signed'(BW'(d1_quot));
      step_sum = (LW+1)'(s1_out.lo) + (LW+1)'(s1_out.idx);
      unique case (s1_out.mode)
         MODE_BOX: begin
            cx_in = s1_out.x1 + d1_rem[C-1:0];
            cy_in = s1_out.y1 + d1_quot[C-1:0];
         end
         MODE_SHALLOW: begin
            cx_in = step_sum[C-1:0];
            cy_in = '0;
         end
         default: begin
            cx_in = '0;
            cy_in = step_sum[C-1:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else begin
         p3_valid_ff <= d1_valid;
      end
      p3_mode_ff     <= s1_out.mode;
      p3_in_range_ff <= s1_out.in_range;
      p3_last_ff     <= s1_out.last;
      p3_color_ff    <= s1_out.color;
      p3_dx_ff       <= s1_out.dx;
      p3_dy_ff       <= s1_out.dy;
      p3_b_ff        <= b_in;
      p3_cx_ff       <= cx_in;
      p3_cy_ff       <= cy_in;
   end

   // ---------------- stage 4: numerator products ----------------
   logic signed [TW-1:0] opa;
   logic signed [SW-1:0] opb;
   logic                 shallow3;

   logic                  p4_valid_ff, p4_in_range_ff, p4_last_ff, p4_dneg_ff;
   mode_type              p4_mode_ff;
   logic [COLOR_BITS-1:0] p4_color_ff;
   logic [C-1:0]          p4_cx_ff, p4_cy_ff;
   logic [NW-1:0]         p4_p1_ff, p4_p2_ff;
   logic [VW-1:0]         p4_dvs_ff;

   always_comb begin
      shallow3 = (p3_mode_ff == MODE_SHALLOW);
      // shallow: dy*x ; steep: (y - b)*dx
      opa = shallow3 ? TW'(signed'(p3_dy_ff))
                     : signed'(TW'(p3_cy_ff)) - TW'(signed'(p3_b_ff));
      opb = shallow3 ? signed'(SW'(p3_cx_ff)) : signed'(p3_dx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff <= 1'b0;
      end else begin
         p4_valid_ff <= p3_valid_ff;
      end
      p4_mode_ff     <= p3_mode_ff;
      p4_in_range_ff <= p3_in_range_ff;
      p4_last_ff     <= p3_last_ff;
      p4_color_ff    <= p3_color_ff;
      p4_cx_ff       <= p3_cx_ff;
      p4_cy_ff       <= p3_cy_ff;
      p4_p1_ff       <= NW'(opa * opb);
      p4_p2_ff       <= shallow3 ? NW'(signed'(p3_b_ff) * signed'(p3_dx_ff)) : '0;
      if (shallow3) begin
         p4_dvs_ff  <= p3_dx_ff[SW-1] ? VW'(-signed'(p3_dx_ff)) : VW'(p3_dx_ff);
         p4_dneg_ff <= p3_dx_ff[SW-1];
      end else begin
         p4_dvs_ff  <= p3_dy_ff[SW-1] ? VW'(-signed'(p3_dy_ff)) : VW'(p3_dy_ff);
         p4_dneg_ff <= p3_dy_ff[SW-1];
      end
   end

   // ---------------- stage 5: numerator sum, second divider ----------------
   logic signed [NW-1:0] num2;
   logic [DW2-1:0]       div2_dividend;
   side2_type            s2_in, s2_out;
   logic                 d2_valid;
   logic [DW2-1:0]       d2_quot;
   logic [VW-1:0]        d2_rem;
   logic [PW2-1:0]       d2_side;

   always_comb begin
      num2 = signed'(p4_p1_ff) + signed'(p4_p2_ff);
      if (p4_mode_ff == MODE_BOX) begin
         div2_dividend = '0;
      end else begin
         div2_dividend = num2[NW-1] ? DW2'(-num2) : DW2'(num2);
      end
      s2_in.mode     = p4_mode_ff;
      s2_in.in_range = p4_in_range_ff;
      s2_in.last     = p4_last_ff;
      s2_in.qneg     = num2[NW-1] ^ p4_dneg_ff;
      s2_in.color    = p4_color_ff;
      s2_in.cx       = p4_cx_ff;
      s2_in.cy       = p4_cy_ff;
   end

   lpr_divider #(.DW(DW2), .VW(VW), .PW(PW2)) u_div_coord (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (p4_valid_ff),
      .in_dividend   (div2_dividend),
      .in_divisor    (p4_dvs_ff),
      .in_side       (PW2'(s2_in)),
      .out_valid     (d2_valid),
      .out_quotient  (d2_quot),
      .out_remainder (d2_rem),
      .out_side      (d2_side)
   );

   assign s2_out = side2_type'(d2_side);

   // ---------------- output stage: coordinates and address ----------------
   logic signed [FW-1:0] qs;
   logic signed [63:0]   px64, py64;
   logic [ADDR_BITS-1:0] addr;
   logic                 hit;
   logic                 rem_unused;

   logic                          rsp_valid_ff, rsp_is_valid_ff, rsp_is_last_ff;
   logic [OUT_BITS-1:0]           rsp_x_ff, rsp_y_ff;
   logic [ADDR_BITS-1:0]          rsp_addr_ff;
   logic [COLOR_BITS-1:0]         rsp_color_ff;

   always_comb begin
      qs = s2_out.qneg ? -signed'(FW'(d2_quot)) : signed'(FW'(d2_quot));
      unique case (s2_out.mode)
         MODE_SHALLOW: begin
            px64 = signed'(64'(s2_out.cx));
            py64 = 64'(qs);
         end
         MODE_STEEP: begin
            px64 = 64'(qs);
            py64 = signed'(64'(s2_out.cy));
         end
         default: begin
            px64 = signed'(64'(s2_out.cx));
            py64 = signed'(64'(s2_out.cy));
         end
      endcase
      addr       = frame_base_ff + (py64[ADDR_BITS-1:0] << ROW_SHIFT) + px64[ADDR_BITS-1:0];
      hit        = d2_valid && s2_out.in_range;
      rem_unused = ^d2_rem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         rsp_is_valid_ff <= 1'b0;
         rsp_is_last_ff  <= 1'b0;
      end else begin
         rsp_valid_ff    <= d2_valid;
         rsp_is_valid_ff <= hit && !px64[63] && !py64[63];
         rsp_is_last_ff  <= hit && s2_out.last;
      end
      rsp_x_ff     <= hit ? px64[OUT_BITS-1:0] : '0;
      rsp_y_ff     <= hit ? py64[OUT_BITS-1:0] : '0;
      rsp_addr_ff  <= hit ? addr : '0;
      rsp_color_ff <= (hit || (rem_unused && 1'b0)) ? s2_out.color : '0;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_x       = signed'(rsp_x_ff);
   assign rsp_pixel_y       = signed'(rsp_y_ff);
   assign rsp_pixel_address = rsp_addr_ff;
   assign rsp_color_out     = rsp_color_ff;
   assign rsp_is_valid      = rsp_is_valid_ff;
   assign rsp_is_last       = rsp_is_last_ff;

endmodule
`default_nettype wire

// ----- src/lpr_checker.sv -----
// lpr_checker: port-level assertions for line_pixel_rasterizer, bound to the top level.
// Depends on lpr_pkg and line_pixel_rasterizer.
`default_nettype none
module lpr_checker #(
   parameter int COORD_BITS = 11
) (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             start,
   input wire logic                             busy,
   input wire logic [lpr_pkg::COLOR_BITS-1:0]   req_color_in,
   input wire logic                             rsp_valid,
   input wire logic [lpr_pkg::COLOR_BITS-1:0]   rsp_color_out,
   input wire logic                             rsp_is_valid,
   input wire logic                             rsp_is_last
);
   import lpr_pkg::*;

   localparam int LAT = lpr_latency(COORD_BITS);
   localparam int SCW = $clog2(LAT + 1);

   logic [SCW-1:0] since_ff, since_in;
   logic           warm;

   // cycles since reset, saturating at the pipeline depth
   always_comb begin
      since_in = (since_ff == SCW'(LAT)) ? since_ff : since_ff + SCW'(1);
      warm     = (since_ff == SCW'(LAT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         since_ff <= '0;
      end else begin
         since_ff <= since_in;
      end
   end

   // no response strobe right after a reset cycle
   a_reset_flush: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response strobe after reset");

   // once warm, the response strobe follows the accepted requests, delayed by the pipeline
   a_latency: assert property (@(posedge clock) disable iff (reset)
      warm |-> (rsp_valid == $past(start && !busy, LAT)))
      else $error("response strobe out of step with requests");

   // flags only with the strobe
   a_flags_strobed: assert property (@(posedge clock)
      !rsp_valid |-> (!rsp_is_valid && !rsp_is_last))
      else $error("flag raised without response strobe");

   // colour of a drawn pixel comes from its own request
   a_color: assert property (@(posedge clock) disable iff (reset)
      (warm && rsp_valid && rsp_is_valid) |-> (rsp_color_out == $past(req_color_in, LAT)))
      else $error("colour does not match request");

endmodule

bind line_pixel_rasterizer lpr_checker #(.COORD_BITS(COORD_BITS)) u_lpr_checker (.*);
`default_nettype wire
